### hdl/sliding_window_threshold_detector_unit_defines.svh
// Assertion macros for the sliding window threshold detector.
`ifndef SLIDING_WINDOW_THRESHOLD_DETECTOR_UNIT_DEFINES_SVH
`define SLIDING_WINDOW_THRESHOLD_DETECTOR_UNIT_DEFINES_SVH

`ifndef NO_ASSERTIONS
// checked only out of reset
`define SWTD_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// checked on every edge, reset included
`define SWTD_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SWTD_ASSERT(name, prop, msg)
`define SWTD_ASSERT_ALWAYS(name, prop, msg)
`endif

`endif

### hdl/swtd_pkg.sv
// Types and constants shared by the sliding window threshold detector.
package swtd_pkg;

  localparam int SWTD_MAX_WINDOW        = 1024;
  localparam int SWTD_MAX_CHUNK_SAMPLES = 4096;

  localparam int CFG_DATA_W  = 22;
  localparam int CFG_INDEX_W = 2;

  localparam logic [CFG_INDEX_W-1:0] REG_THRESHOLD         = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_WINDOW_LENGTH     = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_MIN_COUNT         = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_SAMPLES_PER_CHUNK = 2'd3;

  localparam logic [21:0] THRESHOLD_RST         = 22'd0;
  localparam logic [10:0] WINDOW_LENGTH_RST     = 11'd1024;
  localparam logic [10:0] MIN_COUNT_RST         = 11'd1;
  localparam logic [12:0] SAMPLES_PER_CHUNK_RST = 13'd4096;

  // magnitude scale applied before the threshold compare
  localparam logic [23:0] MAG_SCALE = 24'd100;

  typedef struct packed {
    logic signed [15:0] sample;
    logic [11:0]        sample_index;
    logic [15:0]        chunk_index;
  } swtd_in_t;

  typedef struct packed {
    logic [11:0] end_sample;
    logic [15:0] end_chunk;
    logic [11:0] start_sample;
    logic [15:0] start_chunk;
  } swtd_out_t;

endpackage

### hdl/sliding_window_threshold_detector_unit.sv
// Sliding window k-of-n threshold detector: ring memory of pass bits plus counters.
// A result passes through the stage 1 registers and then the out_valid/out_data registers.
// Throughput: one sample per cycle while out_stall does not hold a pending result; the
// pass count update loops on the registered read of the pass bit memory.
// Reset (rst_n, synchronous) clears counters, ring pointer, positions, configuration and valid flags;
// the pass bit memory is not cleared, and its read bit is used only at entries already written.
`include "sliding_window_threshold_detector_unit_defines.svh"

module sliding_window_threshold_detector_unit
  import swtd_pkg::*;
#(
  parameter int MAX_WINDOW        = SWTD_MAX_WINDOW,
  parameter int MAX_CHUNK_SAMPLES = SWTD_MAX_CHUNK_SAMPLES
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  swtd_in_t               in_data,
  output logic                   out_valid,
  input  logic                   out_stall,
  output swtd_out_t              out_data,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int AW = $clog2(MAX_WINDOW);
  localparam int FW = $clog2(MAX_WINDOW + 1);
  localparam int CW = $clog2(MAX_CHUNK_SAMPLES);

  // configuration
  logic [21:0] threshold_r;
  logic [10:0] window_length_r;
  logic [10:0] min_count_r;
  logic [12:0] samples_per_chunk_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      threshold_r         <= THRESHOLD_RST;
      window_length_r     <= WINDOW_LENGTH_RST;
      min_count_r         <= MIN_COUNT_RST;
      samples_per_chunk_r <= SAMPLES_PER_CHUNK_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_THRESHOLD:         threshold_r         <= cfg_data[21:0];
        REG_WINDOW_LENGTH:     window_length_r     <= cfg_data[10:0];
        REG_MIN_COUNT:         min_count_r         <= cfg_data[10:0];
        REG_SAMPLES_PER_CHUNK: samples_per_chunk_r <= cfg_data[12:0];
        default: begin
        end
      endcase
    end
  end

  // state
  logic [AW-1:0] wp_r, wp_nxt;
  logic [FW-1:0] fill_count_r, fill_count_nxt;
  logic [FW-1:0] pass_count_r, pass_count_nxt;
  logic [CW-1:0] oldest_sample_r, oldest_sample_nxt;
  logic [15:0]   oldest_chunk_r, oldest_chunk_nxt;

  // stage 1 (memory read data stage)
  logic          s1_valid_r;
  logic          s1_passed_r;
  logic          s1_drop_r;
  logic [11:0]   s1_sample_index_r;
  logic [15:0]   s1_chunk_index_r;
  logic [CW-1:0] s1_old_sample_r;
  logic [15:0]   s1_old_chunk_r;
  logic          rd_bit_r;

  logic          out_valid_r;
  swtd_out_t     out_data_r;

  logic          in_acc;
  logic          s1_adv;

  assign s1_adv   = !out_valid_r || !out_stall;
  assign in_stall = s1_valid_r && !s1_adv;
  assign in_acc   = in_valid && !in_stall;

  // stage 0: threshold compare, ring address, window bookkeeping
  logic [16:0]   mag;
  logic [23:0]   scaled;
  logic          passed;
  logic [31:0]   len32, chunk_len32, fill32, ra32, os32;
  logic          drop;
  logic [AW-1:0] rd_addr;

  always_comb begin
    mag    = in_data.sample[15] ? (17'd0 - {1'b1, in_data.sample})
                                : {1'b0, in_data.sample};
    scaled = 24'(mag) * MAG_SCALE;
    passed = scaled > 24'(threshold_r);

    len32 = 32'(window_length_r);
    if (len32 == 32'd0) len32 = 32'd1;
    else if (len32 > 32'(MAX_WINDOW)) len32 = 32'(MAX_WINDOW);

    chunk_len32 = 32'(samples_per_chunk_r);
    if (chunk_len32 == 32'd0) chunk_len32 = 32'd1;
    else if (chunk_len32 > 32'(MAX_CHUNK_SAMPLES)) chunk_len32 = 32'(MAX_CHUNK_SAMPLES);

    fill32 = 32'(fill_count_r);
    drop   = fill32 >= len32;

    // oldest held entry: (wp - fill) mod MAX_WINDOW
    ra32 = 32'(wp_r) + 32'(MAX_WINDOW) - fill32;
    if (ra32 >= 32'(MAX_WINDOW)) ra32 = ra32 - 32'(MAX_WINDOW);
    rd_addr = ra32[AW-1:0];

    wp_nxt = (32'(wp_r) == 32'(MAX_WINDOW - 1)) ? '0 : wp_r + 1'b1;

    fill_count_nxt    = fill_count_r;
    oldest_sample_nxt = oldest_sample_r;
    oldest_chunk_nxt  = oldest_chunk_r;
    os32 = 32'(oldest_sample_r) + 32'd1;
    if (drop) begin
      if (os32 >= chunk_len32) begin
        oldest_sample_nxt = '0;
        oldest_chunk_nxt  = oldest_chunk_r + 16'd1;
      end else begin
        oldest_sample_nxt = os32[CW-1:0];
      end
    end else begin
      fill_count_nxt = fill_count_r + 1'b1;
    end
  end

  // pass bit ring: read-before-write on the same entry returns the old bit
  logic pass_mem [MAX_WINDOW];

  always_ff @(posedge clk) begin
    if (in_acc) begin
      pass_mem[wp_r] <= passed;
      rd_bit_r       <= pass_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r            <= '0;
      fill_count_r    <= '0;
      oldest_sample_r <= '0;
      oldest_chunk_r  <= '0;
      s1_valid_r      <= 1'b0;
    end else begin
      if (in_acc) begin
        wp_r            <= wp_nxt;
        fill_count_r    <= fill_count_nxt;
        oldest_sample_r <= oldest_sample_nxt;
        oldest_chunk_r  <= oldest_chunk_nxt;
        s1_valid_r      <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_r      <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_passed_r       <= passed;
      s1_drop_r         <= drop;
      s1_sample_index_r <= in_data.sample_index;
      s1_chunk_index_r  <= in_data.chunk_index;
      s1_old_sample_r   <= oldest_sample_nxt;
      s1_old_chunk_r    <= oldest_chunk_nxt;
    end
  end

  // stage 1: pass count update and trigger compare
  logic [31:0] pc32;
  logic        fire;
  logic [31:0] old_sample32;

  always_comb begin
    pc32 = 32'(pass_count_r);
    if (s1_drop_r && rd_bit_r && pc32 != 32'd0) pc32 = pc32 - 32'd1;
    pc32 = pc32 + 32'(s1_passed_r);
    pass_count_nxt = pc32[FW-1:0];
    fire           = pc32 == 32'(min_count_r);
    old_sample32   = 32'(s1_old_sample_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pass_count_r <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (s1_valid_r && s1_adv) begin
        pass_count_r <= pass_count_nxt;
        out_valid_r  <= fire;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid_r && s1_adv) begin
      out_data_r.end_sample   <= s1_sample_index_r;
      out_data_r.end_chunk    <= s1_chunk_index_r;
      out_data_r.start_sample <= old_sample32[11:0];
      out_data_r.start_chunk  <= s1_old_chunk_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `SWTD_ASSERT(a_stall_cause, in_stall |-> (s1_valid_r && out_valid_r && out_stall), "input stalled without a blocked result")
  `SWTD_ASSERT(a_pass_le_fill, pass_count_r <= fill_count_r, "pass count exceeds window fill")
  `SWTD_ASSERT(a_out_from_s1, $rose(out_valid_r) |-> $past(s1_valid_r), "result without a sample in stage 1")
  `SWTD_ASSERT(a_oldest_range, 32'(oldest_sample_r) < 32'(MAX_CHUNK_SAMPLES), "oldest sample position out of range")

endmodule

### tb/swtd_event_checker.sv
// Checker for the detector: predicts window events from observed transactions and compares them.
module swtd_event_checker
  import swtd_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  input  logic                   in_stall,
  input  swtd_in_t               in_data,
  input  logic                   out_valid,
  input  logic                   out_stall,
  input  swtd_out_t              out_data,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  output int                     fail_count,
  output int                     pending_results
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SLOT_W = $clog2(SWTD_MAX_WINDOW);

  logic [21:0] threshold_q;
  logic [10:0] window_len_q;
  logic [10:0] min_count_q;
  logic [12:0] chunk_len_q;

  logic              pass_ring [SWTD_MAX_WINDOW];
  logic [SLOT_W-1:0] wr_slot;
  logic [10:0]       fill;
  logic [10:0]       passes;
  logic [12:0]       oldest_sample;
  logic [15:0]       oldest_chunk;

  swtd_out_t pending_events[$];
  int        errors = 0;

  function automatic bit field_matches(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
      return 1'b0;
    end
    return 1'b1;
  endfunction

  task automatic predict_window_event(input swtd_in_t item);
    logic [16:0]       mag;
    logic              passed;
    logic [10:0]       len;
    logic [12:0]       chunk_len;
    logic [SLOT_W-1:0] oldest_slot;
    swtd_out_t         ev;
    mag = item.sample[15] ? 17'h10000 - {1'b0, item.sample} : {1'b0, item.sample};
    passed = ({15'd0, mag} * 32'd100) > {10'd0, threshold_q};

    if (window_len_q == 11'd0) begin
      len = 11'd1;
    end else if (window_len_q > 11'(SWTD_MAX_WINDOW)) begin
      len = 11'(SWTD_MAX_WINDOW);
    end else begin
      len = window_len_q;
    end
    if (chunk_len_q == 13'd0) begin
      chunk_len = 13'd1;
    end else if (chunk_len_q > 13'(SWTD_MAX_CHUNK_SAMPLES)) begin
      chunk_len = 13'(SWTD_MAX_CHUNK_SAMPLES);
    end else begin
      chunk_len = chunk_len_q;
    end

    // fill never shrinks, so a shortened window keeps dropping from the old depth
    if (fill >= len) begin
      oldest_slot = wr_slot - SLOT_W'(fill);
      if (pass_ring[oldest_slot] && passes != 11'd0) passes = passes - 1'b1;
      oldest_sample = oldest_sample + 1'b1;
      if (oldest_sample >= chunk_len) begin
        oldest_sample = '0;
        oldest_chunk  = oldest_chunk + 1'b1;
      end
    end else begin
      fill = fill + 1'b1;
    end

    passes = passes + passed;
    pass_ring[wr_slot] = passed;
    wr_slot = wr_slot + 1'b1;

    if (passes == min_count_q) begin
      ev.end_sample   = item.sample_index;
      ev.end_chunk    = item.chunk_index;
      ev.start_sample = oldest_sample[11:0];
      ev.start_chunk  = oldest_chunk;
      pending_events.push_back(ev);
    end
  endtask

  always @(posedge clk) begin
    swtd_out_t want;
    int        bad;
    if (!rst_n) begin
      threshold_q   = THRESHOLD_RST;
      window_len_q  = WINDOW_LENGTH_RST;
      min_count_q   = MIN_COUNT_RST;
      chunk_len_q   = SAMPLES_PER_CHUNK_RST;
      wr_slot       = '0;
      fill          = '0;
      passes        = '0;
      oldest_sample = '0;
      oldest_chunk  = '0;
      pending_events.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_THRESHOLD:         threshold_q  = cfg_data[21:0];
          REG_WINDOW_LENGTH:     window_len_q = cfg_data[10:0];
          REG_MIN_COUNT:         min_count_q  = cfg_data[10:0];
          REG_SAMPLES_PER_CHUNK: chunk_len_q  = cfg_data[12:0];
          default: ;
        endcase
      end
      // a result never shows in the same cycle as its input's transaction, so compare before predicting
      if (out_valid && !out_stall) begin
        if (pending_events.size() == 0) begin
          $display("%0t: unexpected result: expected none, actual end %0d/%0d start %0d/%0d",
                   $time, out_data.end_sample, out_data.end_chunk,
                   out_data.start_sample, out_data.start_chunk);
          errors++;
        end else begin
          want = pending_events.pop_front();
          bad = 0;
          bad += !field_matches("end_sample", 16'(want.end_sample), 16'(out_data.end_sample));
          bad += !field_matches("end_chunk", want.end_chunk, out_data.end_chunk);
          bad += !field_matches("start_sample", 16'(want.start_sample),
                                16'(out_data.start_sample));
          bad += !field_matches("start_chunk", want.start_chunk, out_data.start_chunk);
          if (bad != 0) errors++;
        end
      end
      if (in_valid && !in_stall) predict_window_event(in_data);
    end
    fail_count      <= errors;
    pending_results <= pending_events.size();
  end

endmodule

### tb/sliding_window_threshold_detector_unit_tb.sv
// Top of the detector testbench: clock, reset, stimulus, output stall and the verdict.
module sliding_window_threshold_detector_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import swtd_pkg::*;

  localparam int N_ITEMS      = 1850;
  localparam int DRAIN_CYCLES = 4;
  localparam int LIMIT_CYCLES = 400000;

  logic                   clk;
  logic                   rst_n     = 1'b0;
  logic                   in_valid  = 1'b0;
  logic                   in_stall;
  swtd_in_t               in_data   = '0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  swtd_out_t              out_data;
  logic                   cfg_we    = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data  = '0;

  int fail_count;
  int pending_results;

  int tx_pct       = 26;
  int rx_pct       = 49;
  int sent         = 0;
  int cycles       = 0;

  // sample generator state for the current phase
  int          level     = 0;
  int          loud_pct  = 30;
  int          chunk_len = 4096;
  int          cur_idx   = 0;
  logic [15:0] cur_chunk = '0;
  int          wide      = 6;

  sliding_window_threshold_detector_unit u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  swtd_event_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_data         (in_data),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_data        (out_data),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .fail_count      (fail_count),
    .pending_results (pending_results)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(0, 99) < rx_pct);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT_CYCLES) begin
      $display("sliding_window_threshold_detector_unit verification failed");
      $finish;
    end
  end

  function automatic swtd_in_t mk_sample(int s, int idx, int chunk);
    swtd_in_t it;
    it.sample       = 16'(s);
    it.sample_index = 12'(idx);
    it.chunk_index  = 16'(chunk);
    return it;
  endfunction

  function automatic swtd_in_t next_item();
    swtd_in_t it;
    int       cap;
    int       mag;
    cap = (level > 32768) ? 32768 : level;
    // noise: any field value, positions out of sequence
    if ($urandom_range(0, 99) < 8) begin
      it.sample       = 16'($urandom);
      it.sample_index = 12'($urandom);
      it.chunk_index  = 16'($urandom);
      return it;
    end
    case ($urandom_range(0, 9))
      0: mag = cap;
      1: mag = (cap < 32768) ? cap + 1 : cap;
      default: begin
        if ($urandom_range(0, 99) < loud_pct && cap < 32768) begin
          mag = $urandom_range(cap + 1, 32768);
        end else begin
          mag = $urandom_range(0, cap);
        end
      end
    endcase
    it.sample = 16'(mag);
    if (mag != 32768 && $urandom_range(0, 1) == 1) it.sample = -it.sample;
    it.sample_index = 12'(cur_idx);
    it.chunk_index  = cur_chunk;
    cur_idx++;
    if (cur_idx >= chunk_len) begin
      cur_idx = 0;
      cur_chunk++;
    end
    return it;
  endfunction

  // called at a rising edge; returns at the edge where the transaction is taken
  task automatic send_item(input swtd_in_t item);
    if (sent < N_ITEMS / 3) begin
      tx_pct = 26;
      rx_pct <= 49;
    end else if (sent < 2 * N_ITEMS / 3) begin
      tx_pct = 49;
      rx_pct <= 26;
    end else begin
      tx_pct = 0;
      rx_pct <= 0;
    end
    while ($urandom_range(0, 99) < tx_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_data  <= item;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent++;
  endtask

  task automatic wait_results_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results != 0) @(posedge clk);
    // a sample that fires nothing may still be in flight
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic program_detector(input logic [21:0] thr, input logic [10:0] win,
                                  input logic [10:0] mc, input logic [12:0] spc);
    wait_results_drained();
    cfg_we    <= 1'b1;
    cfg_index <= REG_THRESHOLD;
    cfg_data  <= thr;
    @(posedge clk);
    cfg_index <= REG_WINDOW_LENGTH;
    cfg_data  <= CFG_DATA_W'(win);
    @(posedge clk);
    cfg_index <= REG_MIN_COUNT;
    cfg_data  <= CFG_DATA_W'(mc);
    @(posedge clk);
    cfg_index <= REG_SAMPLES_PER_CHUNK;
    cfg_data  <= CFG_DATA_W'(spc);
    @(posedge clk);
    cfg_we <= 1'b0;
    level     = int'(thr) / 100;
    chunk_len = (spc == 13'd0) ? 1 :
                (spc > 13'(SWTD_MAX_CHUNK_SAMPLES)) ? SWTD_MAX_CHUNK_SAMPLES : int'(spc);
    cur_idx   = 0;
    cur_chunk = 16'($urandom);
  endtask

  initial begin
    int          n_items;
    int          pause_at;
    int          phase;
    int          eff_len;
    int          base;
    bit          big_done;
    logic [21:0] thr;
    logic [10:0] win;
    logic [10:0] mc;
    logic [12:0] spc;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings; the oldest position starts at 0/0 whatever the indices say
    send_item(mk_sample(0, 0, 0));
    send_item(mk_sample(1, 4095, 65535));
    send_item(mk_sample(-1, 1, 1));

    // zero window and chunk lengths act as one; min count zero fires on no pass
    program_detector(22'd3276799, 11'd0, 11'd0, 13'd0);
    send_item(mk_sample(32767, 2, 2));
    send_item(mk_sample(-32768, 3, 3));
    send_item(mk_sample(0, 4, 4));

    // every register at its field maximum: oversize lengths clamp, nothing fires
    program_detector(22'h3FFFFF, 11'h7FF, 11'h7FF, 13'h1FFF);
    send_item(mk_sample(-32768, 4095, 65535));
    send_item(mk_sample(32767, 0, 0));
    send_item(mk_sample(-1, 7, 9));

    // fill a short window, then shorten it while full
    program_detector(22'd0, 11'd6, 11'd2, 13'd5);
    for (int k = 0; k < 8; k++) send_item(mk_sample(k % 2, k, 100 + k));
    program_detector(22'd0, 11'd2, 11'd1, 13'd5);
    for (int k = 0; k < 4; k++) send_item(mk_sample((k / 2) * 500, k, 200));

    phase    = 0;
    big_done = 1'b0;
    while (sent < N_ITEMS && phase < 40) begin
      case ($urandom_range(0, 7))
        0:       thr = 22'd0;
        1:       thr = 22'($urandom);
        default: thr = 22'(100 * $urandom_range(0, 32768) + $urandom_range(0, 99));
      endcase
      loud_pct = $urandom_range(5, 60);

      if (!big_done && sent >= N_ITEMS - 400) begin
        big_done = 1'b1;
        case ($urandom_range(0, 2))
          0:       win = 11'd1024;
          1:       win = 11'h7FF;
          default: win = 11'($urandom_range(1025, 2047));
        endcase
        n_items = 400;
      end else begin
        case ($urandom_range(0, 9))
          0:       win = 11'd0;
          1:       win = 11'($urandom_range(1, 8));
          default: win = 11'($urandom_range(1, 12 + 4 * phase));
        endcase
        n_items = $urandom_range(90, 160);
      end
      eff_len = (win == 11'd0) ? 1 :
                (win > 11'(SWTD_MAX_WINDOW)) ? SWTD_MAX_WINDOW : int'(win);
      if (eff_len > wide) wide = eff_len;

      // aim the trigger near the expected pass count over the held window
      base = (int'(thr) >= 100 * 32768) ? 0 : (wide * loud_pct * 8 + 500) / 1000;
      case ($urandom_range(0, 7))
        0:       mc = 11'd0;
        1:       mc = 11'(wide + $urandom_range(1, 3));
        default: mc = 11'((base > 0) ? base + $urandom_range(0, 2) - 1 : $urandom_range(0, 1));
      endcase

      case ($urandom_range(0, 9))
        0:       spc = 13'd0;
        1:       spc = 13'h1FFF;
        2:       spc = 13'($urandom);
        3:       spc = 13'(SWTD_MAX_CHUNK_SAMPLES);
        default: spc = 13'($urandom_range(1, 48));
      endcase

      program_detector(thr, win, mc, spc);
      pause_at = (phase == 0 || $urandom_range(0, 2) == 0) ? $urandom_range(1, n_items - 1) : -1;
      for (int k = 0; k < n_items; k++) begin
        if (k == pause_at) wait_results_drained();
        send_item(next_item());
      end
      phase++;
    end

    wait_results_drained();
    if (fail_count == 0) begin
      $display("sliding_window_threshold_detector_unit verification clean");
    end else begin
      $display("sliding_window_threshold_detector_unit verification failed");
    end
    $finish;
  end

endmodule
